/* rtl/npcs_pkg.sv */
package npcs_pkg;

	// palette geometry
	localparam int PALETTE_ENTRIES = 256;
	localparam int IDX_W           = $clog2(PALETTE_ENTRIES);
	localparam int CH_W            = 8;
	localparam int COLOR_W         = 3 * CH_W;
	localparam int SQ_W            = 2 * CH_W;
	localparam int DIST_W          = 18;
	localparam int PORT_IDX_W      = 8;
	localparam int PORT_ENTRIES    = 1 << PORT_IDX_W;

	// item function codes
	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	// control sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_OUTPUT
	} npcs_state_t;

	// one scan step handed to the distance unit
	typedef struct packed {
		logic             valid;
		logic             first;
		logic             last;
		logic [IDX_W-1:0] index;
	} npcs_issue_t;

endpackage

/* rtl/npcs_cell.sv */
module npcs_cell
	import npcs_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               shift_en,
	input  logic [COLOR_W-1:0] shift_in,
	input  logic               wr_en,
	input  logic [COLOR_W-1:0] wr_data,
	output logic [COLOR_W-1:0] color
);

	logic [COLOR_W-1:0] color_q;

	// one palette entry: loaded by a write, passed along the ring during a scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q <= '0;
		end else if (wr_en) begin
			color_q <= wr_data;
		end else if (shift_en) begin
			color_q <= shift_in;
		end
	end

	assign color = color_q;

endmodule

/* rtl/npcs_dist.sv */
module npcs_dist
	import npcs_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  npcs_issue_t        issue,
	input  logic [COLOR_W-1:0] entry,
	input  logic [COLOR_W-1:0] query,
	output logic [IDX_W-1:0]   best_idx,
	output logic [DIST_W-1:0]  best_dist,
	output logic               done
);

	logic              valid_s1;
	logic              first_s1;
	logic              last_s1;
	logic [IDX_W-1:0]  index_s1;
	logic [SQ_W-1:0]   sq_r_s1;
	logic [SQ_W-1:0]   sq_g_s1;
	logic [SQ_W-1:0]   sq_b_s1;
	logic [CH_W-1:0]   d_r;
	logic [CH_W-1:0]   d_g;
	logic [CH_W-1:0]   d_b;
	logic [DIST_W-1:0] dist_sum;
	logic [IDX_W-1:0]  best_idx_q;
	logic [DIST_W-1:0] best_dist_q;
	logic              done_q;

	// absolute channel differences
	function automatic logic [CH_W-1:0] abs_diff(input logic [CH_W-1:0] a,
		input logic [CH_W-1:0] b);
		return (a >= b) ? (a - b) : (b - a);
	endfunction

	always_comb begin
		d_r = abs_diff(query[3*CH_W-1:2*CH_W], entry[3*CH_W-1:2*CH_W]);
		d_g = abs_diff(query[2*CH_W-1:CH_W], entry[2*CH_W-1:CH_W]);
		d_b = abs_diff(query[CH_W-1:0], entry[CH_W-1:0]);
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= issue.valid;
		end
	end

	// stage 1 squares
	always_ff @(posedge clk) begin
		first_s1 <= issue.first;
		last_s1  <= issue.last;
		index_s1 <= issue.index;
		sq_r_s1  <= SQ_W'(d_r) * SQ_W'(d_r);
		sq_g_s1  <= SQ_W'(d_g) * SQ_W'(d_g);
		sq_b_s1  <= SQ_W'(d_b) * SQ_W'(d_b);
	end

	assign dist_sum = DIST_W'(sq_r_s1) + DIST_W'(sq_g_s1) + DIST_W'(sq_b_s1);

	// stage 2 running minimum, earliest index kept on ties
	always_ff @(posedge clk) begin
		if (valid_s1 && (first_s1 || (dist_sum < best_dist_q))) begin
			best_idx_q  <= index_s1;
			best_dist_q <= dist_sum;
		end
	end

	// end of scan pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1 && last_s1;
		end
	end

	assign best_idx  = best_idx_q;
	assign best_dist = best_dist_q;
	assign done      = done_q;

endmodule

/* rtl/nearest_palette_color_search.sv */
// Nearest palette color search.
// Input channel (in_valid/in_ready) takes two kinds of items. func = write
// stores red/green/blue into entry entry_index and gives no result; indexes
// beyond the palette are dropped. func = query scans the whole palette for
// the entry with the least squared RGB distance.
// Output channel (out_valid/out_ready) carries one result per query: the
// first index with the least distance, that distance and an exact-match flag.
// The palette sits in a ring of cells that rotates one entry per cycle while
// a query runs, so the scan visits every entry in turn at the ring head;
// the distance unit is a two-stage pipeline fed by the ring head.
// A full rotation always runs, which leaves the ring back in place.
// in_ready is high only between queries; writes are taken one per cycle.
// A result waits in the output register while out_ready is low; the next item
// is still taken, and a later query holds its result until the register frees.
// Reset clears every palette entry to black and empties the output register.
module nearest_palette_color_search
	import npcs_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  func,
	input  logic [PORT_IDX_W-1:0] entry_index,
	input  logic [CH_W-1:0]       red,
	input  logic [CH_W-1:0]       green,
	input  logic [CH_W-1:0]       blue,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [PORT_IDX_W-1:0] best_index,
	output logic [DIST_W-1:0]     best_distance,
	output logic                  exact_match
);

	npcs_state_t         state_q;
	npcs_state_t         state_d;
	logic [IDX_W-1:0]    cnt_q;
	logic [COLOR_W-1:0]  query_q;
	logic [COLOR_W-1:0]  in_color;
	logic [COLOR_W-1:0]  ring [PALETTE_ENTRIES];
	logic                in_xfer;
	logic                wr_xfer;
	logic                scan_last;
	logic                shift_en;
	logic                load;
	logic                out_free;
	npcs_issue_t         issue;
	logic [IDX_W-1:0]    best_idx;
	logic [DIST_W-1:0]   best_dist;
	logic                done;
	logic                out_valid_q;
	logic [PORT_IDX_W-1:0] best_index_q;
	logic [DIST_W-1:0]   best_distance_q;
	logic                exact_match_q;

	assign in_color  = {red, green, blue};
	assign in_xfer   = in_valid && in_ready;
	assign wr_xfer   = in_xfer && (func == FUNC_WRITE);
	assign scan_last = (cnt_q == IDX_W'(PALETTE_ENTRIES - 1));
	assign out_free  = !out_valid_q || out_ready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_xfer && (func == FUNC_QUERY)) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (scan_last) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (done) state_d = ST_OUTPUT;
			end
			ST_OUTPUT: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		in_ready = 1'b0;
		shift_en = 1'b0;
		load     = 1'b0;
		case (state_q)
			ST_IDLE:   in_ready = 1'b1;
			ST_SCAN:   shift_en = 1'b1;
			ST_DRAIN:  ;
			ST_OUTPUT: load = out_free;
			default:   ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (shift_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
		end
	end

	// query color held for the scan
	always_ff @(posedge clk) begin
		if (in_xfer && (func == FUNC_QUERY)) begin
			query_q <= in_color;
		end
	end

	// ring of palette cells, head at cell zero
	for (genvar i = 0; i < PALETTE_ENTRIES; i++) begin : g_cell
		logic wr_en;
		if (i < PORT_ENTRIES) begin : g_wr
			assign wr_en = wr_xfer && (entry_index == PORT_IDX_W'(i));
		end else begin : g_nowr
			assign wr_en = 1'b0;
		end
		npcs_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift_en (shift_en),
			.shift_in (ring[(i + 1) % PALETTE_ENTRIES]),
			.wr_en    (wr_en),
			.wr_data  (in_color),
			.color    (ring[i])
		);
	end

	// scan step for the distance unit
	always_comb begin
		issue.valid = shift_en;
		issue.first = (cnt_q == '0);
		issue.last  = scan_last;
		issue.index = cnt_q;
	end

	npcs_dist u_dist (
		.clk       (clk),
		.arst_n    (arst_n),
		.issue     (issue),
		.entry     (ring[0]),
		.query     (query_q),
		.best_idx  (best_idx),
		.best_dist (best_dist),
		.done      (done)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			best_index_q    <= PORT_IDX_W'(best_idx);
			best_distance_q <= best_dist;
			exact_match_q   <= (best_dist == '0);
		end
	end

	assign out_valid     = out_valid_q;
	assign best_index    = best_index_q;
	assign best_distance = best_distance_q;
	assign exact_match   = exact_match_q;

endmodule

/* rtl/npcs_checker.sv */
module npcs_checker
	import npcs_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  func,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [PORT_IDX_W-1:0] best_index,
	input logic [DIST_W-1:0]     best_distance,
	input logic                  exact_match
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(best_index) && $stable(best_distance)
			&& $stable(exact_match))
		else $error("result payload changed while stalled");

	// exact flag agrees with the distance
	a_exact: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (exact_match == (best_distance == '0)))
		else $error("exact match flag disagrees with distance");

	// a query transfer closes the input
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (func == FUNC_QUERY) |=> !in_ready)
		else $error("input taken during a scan");

endmodule

bind nearest_palette_color_search npcs_checker u_npcs_checker (.*);

/* sim/nearest_palette_color_search_tb.sv */
module nearest_palette_color_search_tb;
	import npcs_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int TOTAL_ITEMS     = 1700;
	localparam int CALM_ITEMS      = 150;
	localparam int HOLD_AT_ITEM    = 400;
	localparam int HOLD_CYCLES     = 1200;
	localparam int DRAIN_AT_ITEM   = 900;
	localparam int SETTLE_CYCLES   = 300;
	localparam int LIMIT_CYCLES    = 2_000_000;
	localparam int REPORT_LIMIT    = 10;
	localparam int DIRECTED_COUNT  = 20;

	// one nearest-color answer as seen on the output channel
	typedef struct packed {
		logic [PORT_IDX_W-1:0] index;
		logic [DIST_W-1:0]     distance;
		logic                  exact;
	} nearest_t;

	// one row of the directed stimulus; fixed rows carry a hand-written answer
	typedef struct packed {
		logic                  func;
		logic [PORT_IDX_W-1:0] idx;
		logic [COLOR_W-1:0]    color;
		logic                  fixed;
		nearest_t              want;
	} stim_row_t;

	localparam nearest_t NO_ANSWER = '0;

	localparam stim_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
		// black palette after reset: exact hit on entry 0, then the far corner
		'{FUNC_QUERY, 8'h00, 24'h000000, 1'b1, '{8'd0, 18'd0, 1'b1}},
		'{FUNC_QUERY, 8'hFF, 24'hFFFFFF, 1'b1, '{8'd0, 18'd195075, 1'b0}},
		// white in the last entry
		'{FUNC_WRITE, 8'hFF, 24'hFFFFFF, 1'b0, NO_ANSWER},
		'{FUNC_QUERY, 8'h00, 24'hFFFFFF, 1'b1, '{8'd255, 18'd0, 1'b1}},
		// entry 0 turns red, black now first found at entry 1
		'{FUNC_WRITE, 8'h00, 24'hFF0000, 1'b0, NO_ANSWER},
		'{FUNC_QUERY, 8'h00, 24'h000000, 1'b0, NO_ANSWER},
		'{FUNC_QUERY, 8'h00, 24'hFF0000, 1'b1, '{8'd0, 18'd0, 1'b1}},
		// same color in two entries: lowest index wins a tie
		'{FUNC_WRITE, 8'h0A, 24'h0C2238, 1'b0, NO_ANSWER},
		'{FUNC_WRITE, 8'h14, 24'h0C2238, 1'b0, NO_ANSWER},
		'{FUNC_QUERY, 8'h00, 24'h0D2238, 1'b0, NO_ANSWER},
		'{FUNC_QUERY, 8'h00, 24'h0C2238, 1'b1, '{8'd10, 18'd0, 1'b1}},
		// alternating bit patterns on index and channels
		'{FUNC_WRITE, 8'hAA, 24'hAA55AA, 1'b0, NO_ANSWER},
		'{FUNC_WRITE, 8'h55, 24'h55AA55, 1'b0, NO_ANSWER},
		'{FUNC_QUERY, 8'h55, 24'h55AA55, 1'b1, '{8'd85, 18'd0, 1'b1}},
		'{FUNC_QUERY, 8'hAA, 24'hAA55AB, 1'b0, NO_ANSWER},
		// mid gray and near misses
		'{FUNC_WRITE, 8'h80, 24'h808080, 1'b0, NO_ANSWER},
		'{FUNC_QUERY, 8'h00, 24'h7F8180, 1'b0, NO_ANSWER},
		'{FUNC_QUERY, 8'h00, 24'h00FF00, 1'b0, NO_ANSWER},
		'{FUNC_QUERY, 8'hFF, 24'hFF00FF, 1'b0, NO_ANSWER},
		'{FUNC_QUERY, 8'h00, 24'hFFFFFE, 1'b0, NO_ANSWER}
	};

	logic                  clk;
	logic                  arst_n      = 1'b0;
	logic                  in_valid    = 1'b0;
	logic                  in_ready;
	logic                  func        = FUNC_WRITE;
	logic [PORT_IDX_W-1:0] entry_index = '0;
	logic [CH_W-1:0]       red         = '0;
	logic [CH_W-1:0]       green       = '0;
	logic [CH_W-1:0]       blue        = '0;
	logic                  out_valid;
	logic                  out_ready   = 1'b0;
	logic [PORT_IDX_W-1:0] best_index;
	logic [DIST_W-1:0]     best_distance;
	logic                  exact_match;

	logic [COLOR_W-1:0] palette_copy [PALETTE_ENTRIES];
	nearest_t           pending_nearest [$];

	int unsigned items_sent;
	int unsigned palette_writes;
	int unsigned color_queries;
	int unsigned results_checked;
	int unsigned fail_count;
	int unsigned cycle_count;
	int unsigned gap_rate = 2;
	bit          calm;
	bit          hold_done;

	nearest_palette_color_search dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.entry_index  (entry_index),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.best_index   (best_index),
		.best_distance(best_distance),
		.exact_match  (exact_match)
	);

	// free-running clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d results still owed", cycle_count,
				pending_nearest.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic int unsigned chan_dist_sq(input logic [CH_W-1:0] a,
		input logic [CH_W-1:0] b);
		int unsigned d;
		d = (a >= b) ? int'(a) - int'(b) : int'(b) - int'(a);
		return d * d;
	endfunction

	// palette scan, first index of least squared distance, ends at an exact hit
	function automatic nearest_t find_nearest(input logic [COLOR_W-1:0] color);
		nearest_t    res;
		int unsigned dist_sum;
		int unsigned best_dist;
		int          best;
		best      = 0;
		best_dist = 0;
		for (int i = 0; i < PALETTE_ENTRIES; i++) begin
			dist_sum = chan_dist_sq(color[23:16], palette_copy[i][23:16])
				+ chan_dist_sq(color[15:8], palette_copy[i][15:8])
				+ chan_dist_sq(color[7:0], palette_copy[i][7:0]);
			if (i == 0 || dist_sum < best_dist) begin
				best      = i;
				best_dist = dist_sum;
			end
			if (dist_sum == 0)
				break;
		end
		res.index    = best[PORT_IDX_W-1:0];
		res.distance = best_dist[DIST_W-1:0];
		res.exact    = (best_dist == 0);
		return res;
	endfunction

	function automatic logic [CH_W-1:0] nudge(input logic [CH_W-1:0] v);
		int t;
		t = int'(v) + int'($urandom_range(0, 6)) - 3;
		if (t < 0)
			t = 0;
		if (t > 255)
			t = 255;
		return t[CH_W-1:0];
	endfunction

	function automatic logic [CH_W-1:0] edge_channel();
		int unsigned pick;
		pick = $urandom_range(0, 2);
		if (pick == 0)
			return 8'h00;
		if (pick == 1)
			return 8'hFF;
		return CH_W'($urandom_range(0, 255));
	endfunction

	task automatic log_failure(input string msg);
		fail_count++;
		if (fail_count <= REPORT_LIMIT)
			$display("MISMATCH at cycle %0d: %s", cycle_count, msg);
	endtask

	// offer one item until taken; update the palette copy or queue its answer
	task automatic drive(input logic f, input logic [PORT_IDX_W-1:0] idx,
		input logic [COLOR_W-1:0] color, input logic fixed, input nearest_t want);
		in_valid    <= 1'b1;
		func        <= f;
		entry_index <= idx;
		red         <= color[23:16];
		green       <= color[15:8];
		blue        <= color[7:0];
		do
			@(posedge clk);
		while (in_ready !== 1'b1);
		if (f == FUNC_WRITE) begin
			if (idx < PALETTE_ENTRIES)
				palette_copy[idx] = color;
			palette_writes++;
		end else begin
			pending_nearest.push_back(fixed ? want : find_nearest(color));
			color_queries++;
		end
		items_sent++;
		if (!calm && gap_rate != 0 && $urandom_range(1, 8) <= gap_rate) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_nearest.size() != 0);
	endtask

	// result checker
	always @(posedge clk) begin
		nearest_t got;
		nearest_t want;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			got = '{best_index, best_distance, exact_match};
			if (pending_nearest.size() == 0) begin
				log_failure($sformatf("unexpected result index %0d distance %0d exact %0b",
					got.index, got.distance, got.exact));
			end else begin
				want = pending_nearest.pop_front();
				if (got.index !== want.index || got.distance !== want.distance ||
					got.exact !== want.exact)
					log_failure($sformatf(
						"expected index %0d distance %0d exact %0b, got %0d %0d %0b",
						want.index, want.distance, want.exact,
						got.index, got.distance, got.exact));
				results_checked++;
			end
		end
	end

	// output side: random stall bursts, one long hold-off, none at the end
	initial begin
		int unsigned stall_rate;
		int unsigned mode_cycles;
		stall_rate  = 3;
		mode_cycles = 0;
		forever begin
			@(posedge clk);
			mode_cycles++;
			if (mode_cycles % 256 == 0)
				stall_rate = $urandom_range(0, 2) * 3;
			if (calm || !arst_n) begin
				out_ready <= 1'b1;
			end else if (!hold_done && items_sent >= HOLD_AT_ITEM) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
				out_ready <= 1'b1;
			end else if (stall_rate != 0 && $urandom_range(1, stall_rate * 2) == 1) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// stimulus
	initial begin
		stim_row_t             row;
		int unsigned           mode;
		int unsigned           pick;
		int unsigned           run_len;
		logic [PORT_IDX_W-1:0] base;
		logic [COLOR_W-1:0]    color;
		bit                    paused;
		paused = 1'b0;
		for (int i = 0; i < PALETTE_ENTRIES; i++)
			palette_copy[i] = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed table
		for (int i = 0; i < DIRECTED_COUNT; i++) begin
			row = DIRECTED_ROWS[i];
			drive(row.func, row.idx, row.color, row.fixed, row.want);
		end
		wait_drained();

		// random palette updates and queries
		while (items_sent < TOTAL_ITEMS) begin
			calm = (items_sent >= TOTAL_ITEMS - CALM_ITEMS);
			if ($urandom_range(0, 7) == 0)
				gap_rate = $urandom_range(0, 3);
			if (!paused && items_sent >= DRAIN_AT_ITEM) begin
				wait_drained();
				paused = 1'b1;
			end
			mode = $urandom_range(0, 9);
			if (mode <= 2) begin
				// short burst of writes, some copying existing colors for ties
				repeat ($urandom_range(1, 6)) begin
					pick = $urandom_range(0, 9);
					if (pick < 7)
						color = COLOR_W'($urandom);
					else if (pick < 9)
						color = palette_copy[IDX_W'($urandom_range(0, PALETTE_ENTRIES - 1))];
					else
						color = {edge_channel(), edge_channel(), edge_channel()};
					drive(FUNC_WRITE, PORT_IDX_W'($urandom_range(0, 255)), color, 1'b0,
						NO_ANSWER);
				end
			end else if (mode <= 8) begin
				// query: exact hit, near miss, random or corner color
				pick  = $urandom_range(0, 19);
				color = palette_copy[IDX_W'($urandom_range(0, PALETTE_ENTRIES - 1))];
				if (pick >= 7 && pick < 14)
					color = {nudge(color[23:16]), nudge(color[15:8]), nudge(color[7:0])};
				else if (pick >= 14 && pick < 17)
					color = COLOR_W'($urandom);
				else if (pick >= 17)
					color = {edge_channel(), edge_channel(), edge_channel()};
				drive(FUNC_QUERY, PORT_IDX_W'($urandom_range(0, 255)), color, 1'b0,
					NO_ANSWER);
			end else begin
				// run of equal entries, then a query close to them
				base    = PORT_IDX_W'($urandom_range(0, 255));
				color   = COLOR_W'($urandom);
				run_len = $urandom_range(2, 4);
				for (int k = 0; k < run_len; k++)
					drive(FUNC_WRITE, base + k[PORT_IDX_W-1:0], color, 1'b0, NO_ANSWER);
				color = {nudge(color[23:16]), nudge(color[15:8]), nudge(color[7:0])};
				drive(FUNC_QUERY, PORT_IDX_W'($urandom_range(0, 255)), color, 1'b0,
					NO_ANSWER);
			end
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("covered %0d palette writes and %0d color queries, %0d results compared",
			palette_writes, color_queries, results_checked);
		$display("ties, exact hits, corner colors, a %0d-cycle output hold and a drain pause",
			HOLD_CYCLES);
		if (fail_count == 0 && pending_nearest.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("%0d failures, %0d results missing", fail_count,
				pending_nearest.size());
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
